// ===== src/vctc_pkg.sv =====
`default_nettype none

package vctc_pkg;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_WR_CTRL  = 3'd1,
        CMD_WR_CMP   = 3'd2,
        CMD_WR_TVAL  = 3'd3,
        CMD_READ     = 3'd4
    } command_t;

    localparam int CTL_W       = 3;
    localparam int CMD_W       = 3;
    localparam int COUNT_W     = 64;
    localparam int TVAL_W      = 32;
    localparam int FIRE_W      = 32;
    localparam int STALE_W     = 32;

    // Bit positions inside the control register.
    localparam int CTL_ENABLE  = 0;
    localparam int CTL_MASK    = 1;
    localparam int CTL_STATUS  = 2;

    localparam logic [STALE_W-1:0] STALE_RESET = 32'd6250000;

    localparam int S_DATA_W    = 168;
    localparam int M_DATA_W    = 136;

endpackage

`default_nettype wire

// ===== src/virtual_compare_timer_channel.sv =====
// Path: an item accepted at the input is held in the input register, and its result
// is written from there to the result register; the item waits in the input register
// while the result side stalls.
// Throughput: one item per cycle while the result side does not stall; the register
// update of each item is done between the input register and the result register.
// Reset (aresetn, synchronous, active low) empties both registers, clears the
// channel state and loads the stale pending tick count with 6250000.
`default_nettype none

module virtual_compare_timer_channel (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [vctc_pkg::STALE_W-1:0]   cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata from bit 0: counter_now[63:0], control_in[2:0], compare_in[63:0],
    // timer_value_in[31:0], zero fill
    input  wire logic [vctc_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser from bit 0: command[2:0]
    input  wire logic [vctc_pkg::CMD_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata from bit 0: control_out[2:0], compare_out[63:0], timer_value_out[31:0],
    // irq_raise, pending_out, fire_total[31:0], zero fill
    output logic [vctc_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int CW = vctc_pkg::COUNT_W;

    // Input register
    logic                               in_valid_reg;
    logic [vctc_pkg::CMD_W-1:0]         in_cmd_reg;
    logic [CW-1:0]                      in_counter_reg;
    logic [vctc_pkg::CTL_W-1:0]         in_ctl_reg;
    logic [CW-1:0]                      in_cmp_reg;
    logic signed [vctc_pkg::TVAL_W-1:0] in_tval_reg;

    // Channel state
    logic [vctc_pkg::STALE_W-1:0]       stale_reg;
    logic [vctc_pkg::CTL_W-1:0]         control_reg, control_next;
    logic [CW-1:0]                      compare_reg, compare_next;
    logic [CW-1:0]                      counter_reg, counter_next;
    logic                               pending_reg, pending_next;
    logic [vctc_pkg::FIRE_W-1:0]        fire_count_reg, fire_count_next;
    logic [CW-1:0]                      last_fire_reg, last_fire_next;

    // Result register
    logic                               out_valid_reg;
    logic [vctc_pkg::M_DATA_W-1:0]      out_data_reg, out_data_next;

    logic                               proc;
    logic [CW-1:0]                      since;
    logic                               stale;
    logic                               reached;
    logic                               irq;
    logic signed [vctc_pkg::TVAL_W-1:0] tval_out;
    logic [CW-1:0]                      tval_ext;

    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign since    = in_counter_reg - last_fire_reg;
    assign stale    = since > {{(CW-vctc_pkg::STALE_W){1'b0}}, stale_reg};
    assign reached  = in_counter_reg >= compare_reg;
    assign tval_ext = {{(CW-vctc_pkg::TVAL_W){in_tval_reg[vctc_pkg::TVAL_W-1]}}, in_tval_reg};

    always_comb begin
        control_next    = control_reg;
        compare_next    = compare_reg;
        counter_next    = counter_reg;
        pending_next    = pending_reg;
        fire_count_next = fire_count_reg;
        last_fire_next  = last_fire_reg;
        irq             = 1'b0;
        unique case (in_cmd_reg)
            vctc_pkg::CMD_TICK: begin
                counter_next = in_counter_reg;
                // A pending status left set too long is dropped first, so the
                // same tick may fire again.
                if (pending_reg && stale) begin
                    pending_next = 1'b0;
                    control_next[vctc_pkg::CTL_STATUS] = 1'b0;
                end
                if (control_next[vctc_pkg::CTL_ENABLE] && reached && !pending_next) begin
                    pending_next    = 1'b1;
                    control_next[vctc_pkg::CTL_STATUS] = 1'b1;
                    fire_count_next = fire_count_reg + 1'b1;
                    last_fire_next  = in_counter_reg;
                    irq             = !control_next[vctc_pkg::CTL_MASK];
                end
            end
            vctc_pkg::CMD_WR_CTRL: begin
                if (control_reg[vctc_pkg::CTL_STATUS] && !in_ctl_reg[vctc_pkg::CTL_STATUS]) begin
                    pending_next = 1'b0;
                end
                control_next = in_ctl_reg;
            end
            vctc_pkg::CMD_WR_CMP: begin
                compare_next = in_cmp_reg;
                if (control_reg[vctc_pkg::CTL_STATUS]) begin
                    control_next[vctc_pkg::CTL_STATUS] = 1'b0;
                    pending_next = 1'b0;
                end
            end
            vctc_pkg::CMD_WR_TVAL: begin
                compare_next = counter_reg + tval_ext;
                if (control_reg[vctc_pkg::CTL_STATUS]) begin
                    control_next[vctc_pkg::CTL_STATUS] = 1'b0;
                    pending_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // The low half of (count + value) - count is the value itself, which keeps
    // the adder off the result path for timer value writes.
    always_comb begin
        if (in_cmd_reg == vctc_pkg::CMD_WR_TVAL) begin
            tval_out = in_tval_reg;
        end else begin
            tval_out = signed'(compare_next[vctc_pkg::TVAL_W-1:0]
                               - counter_next[vctc_pkg::TVAL_W-1:0]);
        end
        out_data_next = {3'b000, fire_count_next, pending_next, irq, tval_out,
                         compare_next, control_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cmd_reg     <= s_tuser;
            in_counter_reg <= s_tdata[63:0];
            in_ctl_reg     <= s_tdata[66:64];
            in_cmp_reg     <= s_tdata[130:67];
            in_tval_reg    <= signed'(s_tdata[162:131]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_reg      <= vctc_pkg::STALE_RESET;
            control_reg    <= '0;
            compare_reg    <= '0;
            counter_reg    <= '0;
            pending_reg    <= 1'b0;
            fire_count_reg <= '0;
            last_fire_reg  <= '0;
        end else begin
            if (cfg_we) begin
                stale_reg <= cfg_wdata;
            end
            if (proc) begin
                control_reg    <= control_next;
                compare_reg    <= compare_next;
                counter_reg    <= counter_next;
                pending_reg    <= pending_next;
                fire_count_reg <= fire_count_next;
                last_fire_reg  <= last_fire_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // Every way of dropping the status bit also drops pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> control_reg[vctc_pkg::CTL_STATUS])
        else $error("pending set while status is clear");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[99]) |-> (m_tdata[100] && m_tdata[2]))
        else $error("interrupt raised without pending and status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_cmd_reg != vctc_pkg::CMD_TICK) |=> $stable(fire_count_reg))
        else $error("fire count moved on a non-tick item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");
`endif

endmodule

`default_nettype wire
